// ===== src/cmdtok_pkg.sv =====
// Shared types and constants for the command tokenizer decoder.
// No dependencies; imported by every module of the block.
package cmdtok_pkg;

    localparam logic [7:0] CHAR_END   = 8'd0;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [31:0] HEX_ALPHA_OFFSET = 32'd55;

    localparam int KW_COUNT = 3;

    typedef enum logic [1:0] {
        KIND_KEYWORD = 2'd0,
        KIND_NUMBER  = 2'd1,
        KIND_STRING  = 2'd2,
        KIND_NONE    = 2'd3
    } token_kind_t;

    typedef enum logic [1:0] {
        KW_LOAD  = 2'd0,
        KW_STORE = 2'd1,
        KW_RESET = 2'd2
    } keyword_code_t;

    typedef enum logic [1:0] {
        PH_DELIM = 2'b01,
        PH_TOKEN = 2'b10
    } scan_phase_t;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [1:0]  keyword_code;
        logic [31:0] number_value;
        logic [1:0]  token_index;
        logic [7:0]  token_start;
        logic [7:0]  token_length;
        logic [1:0]  tokens_found;
        logic        message_end;
    } result_t;

    function automatic logic [7:0] kw_len(input logic [1:0] k);
        logic [7:0] len;
        unique case (k)
            KW_LOAD:  len = 8'd4;
            KW_STORE: len = 8'd5;
            KW_RESET: len = 8'd5;
            default:  len = 8'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
        logic [39:0] text;
        unique case (k)
            KW_LOAD:  text = {8'h00, "daol"};
            KW_STORE: text = "erots";
            KW_RESET: text = "teser";
            default:  text = 40'd0;
        endcase
        return (i < 3'd5) ? text[i*8 +: 8] : 8'd0;
    endfunction

endpackage

// ===== src/cmdtok_scan.sv =====
// Scanner state and per-byte decode of the command tokenizer.
// Depends on cmdtok_pkg.
module cmdtok_scan #(
    parameter int MAX_TOKENS        = 3,
    parameter int MAX_MESSAGE_BYTES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic [7:0]          char_code,
    output logic                res_valid,
    output cmdtok_pkg::result_t res
);
    import cmdtok_pkg::*;

    localparam logic [7:0] POS_LAST  = 8'(MAX_MESSAGE_BYTES - 1);
    localparam logic [1:0] TOK_LIMIT = 2'(MAX_TOKENS);

    scan_phase_t phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [1:0]  count_reg, count_next;
    logic [7:0]  start_reg, start_next;
    logic [7:0]  len_reg, len_next;
    logic [2:0]  kw_reg, kw_next;
    logic        hex_reg, hex_next;
    logic [31:0] acc_reg, acc_next;

    result_t     token_res;
    logic [7:0]  feed_len;
    logic [2:0]  feed_kw;
    logic        feed_hex;
    logic [31:0] feed_acc;
    logic [31:0] digit;
    logic        found;

    // classify the token held in state
    always_comb begin
        token_res = '0;
        token_res.token_kind = KIND_STRING;
        found = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (!found && kw_reg[k] && len_reg == kw_len(2'(k))) begin
                found = 1'b1;
                token_res.token_kind = KIND_KEYWORD;
                token_res.keyword_code = 2'(k);
            end
        end
        if (!found && hex_reg && len_reg >= 8'd3) begin
            token_res.token_kind = KIND_NUMBER;
            token_res.number_value = acc_reg;
        end
        token_res.token_index = count_reg - 2'd1;
        token_res.token_start = start_reg;
        token_res.token_length = len_reg;
        token_res.tokens_found = count_reg;
    end

    // feed one byte into the token state
    always_comb begin
        logic       fresh;
        logic [7:0] base_len;
        logic [2:0] base_kw;
        logic       base_hex;
        logic [31:0] base_acc;
        fresh    = (phase_reg == PH_DELIM);
        base_len = fresh ? 8'd0 : len_reg;
        base_kw  = fresh ? 3'b111 : kw_reg;
        base_hex = fresh ? 1'b1 : hex_reg;
        base_acc = fresh ? 32'd0 : acc_reg;

        for (int k = 0; k < KW_COUNT; k++) begin
            feed_kw[k] = base_kw[k] && (base_len < kw_len(2'(k)))
                         && (kw_char(2'(k), base_len[2:0]) == char_code);
        end

        digit = (char_code < CHAR_UPPER_A) ? ({24'd0, char_code} - {24'd0, CHAR_ZERO})
                                           : ({24'd0, char_code} - HEX_ALPHA_OFFSET);
        feed_hex = base_hex;
        feed_acc = base_acc;
        if (base_hex) begin
            priority if (base_len == 8'd0) begin
                feed_hex = (char_code == CHAR_ZERO);
            end else if (base_len == 8'd1) begin
                feed_hex = (char_code == CHAR_X);
            end else if (base_len <= 8'd5) begin
                feed_acc = {base_acc[27:0], 4'd0} | digit;
            end else begin
                feed_hex = 1'b0;
            end
        end
        feed_len = (base_len == 8'hFF) ? base_len : base_len + 8'd1;
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kw_next    = kw_reg;
        hex_next   = hex_reg;
        acc_next   = acc_reg;
        res_valid  = 1'b0;
        res        = token_res;

        if (char_code == CHAR_END) begin
            res_valid = 1'b1;
            if (phase_reg == PH_TOKEN) begin
                res.message_end = 1'b1;
            end else begin
                res = '0;
                res.token_kind = KIND_NONE;
                res.tokens_found = count_reg;
                res.message_end = 1'b1;
            end
            phase_next = PH_DELIM;
            pos_next   = 8'd0;
            count_next = 2'd0;
            start_next = 8'd0;
            len_next   = 8'd0;
            kw_next    = 3'b111;
            hex_next   = 1'b1;
            acc_next   = 32'd0;
        end else begin
            if (pos_reg < POS_LAST) begin
                pos_next = pos_reg + 8'd1;
            end
            if (char_code == CHAR_SPACE) begin
                if (phase_reg == PH_TOKEN) begin
                    res_valid  = 1'b1;
                    phase_next = PH_DELIM;
                end
            end else if (phase_reg == PH_TOKEN || count_reg < TOK_LIMIT) begin
                if (phase_reg == PH_DELIM) begin
                    count_next = count_reg + 2'd1;
                    start_next = pos_reg;
                    phase_next = PH_TOKEN;
                end
                len_next = feed_len;
                kw_next  = feed_kw;
                hex_next = feed_hex;
                acc_next = feed_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DELIM;
            pos_reg   <= 8'd0;
            count_reg <= 2'd0;
            start_reg <= 8'd0;
            len_reg   <= 8'd0;
            kw_reg    <= 3'b111;
            hex_reg   <= 1'b1;
            acc_reg   <= 32'd0;
        end else if (take) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
            hex_reg   <= hex_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// ===== src/cmdtok_out_reg.sv =====
// Result register of the command tokenizer: holds one result until taken.
// Depends on cmdtok_pkg.
module cmdtok_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  cmdtok_pkg::result_t load_data,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output cmdtok_pkg::result_t data
);
    import cmdtok_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);
    assign m_valid    = valid_reg;
    assign data       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== src/command_tokenizer_decoder.sv =====
// Command tokenizer decoder top level: byte input, token result output.
// Depends on cmdtok_pkg, cmdtok_scan and cmdtok_out_reg.
//
// Usage:
//   Input channel s_*: one message byte per request; 32 separates tokens,
//   0 ends the message. Output channel m_*: one result per finished token
//   (keyword, number or string); a message end gives one result, the
//   open token's if any. Other spaces, ignored bytes and bytes inside a
//   token give none. Throughput: one byte per cycle unless stalled.
//   A closing byte's result shows on m_* in the cycle after acceptance.
//   Scanner state advances at acceptance; the result register sits
//   between scanner and m_*, so s_ready stays high while the held result
//   is being taken in the same cycle.
//   When the receiver stalls with a result held, s_ready drops and the
//   block holds all state until m_ready returns.
//   Reset (aresetn low, synchronous) empties the result register and
//   returns the scanner to the start of a message.
module command_tokenizer_decoder #(
    parameter int MAX_TOKENS        = 3,
    parameter int MAX_MESSAGE_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_token_kind,
    output logic [1:0]  m_keyword_code,
    output logic [31:0] m_number_value,
    output logic [1:0]  m_token_index,
    output logic [7:0]  m_token_start,
    output logic [7:0]  m_token_length,
    output logic [1:0]  m_tokens_found,
    output logic        m_message_end
);
    import cmdtok_pkg::*;

    logic    take;
    logic    res_valid;
    logic    free;
    result_t res;
    result_t held;

    assign s_ready = free;
    assign take    = s_valid && free;

    cmdtok_scan #(
        .MAX_TOKENS        (MAX_TOKENS),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .char_code (s_char_code),
        .res_valid (res_valid),
        .res       (res)
    );

    cmdtok_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take && res_valid),
        .load_data (res),
        .free      (free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .data      (held)
    );

    assign m_token_kind   = held.token_kind;
    assign m_keyword_code = held.keyword_code;
    assign m_number_value = held.number_value;
    assign m_token_index  = held.token_index;
    assign m_token_start  = held.token_start;
    assign m_token_length = held.token_length;
    assign m_tokens_found = held.tokens_found;
    assign m_message_end  = held.message_end;

endmodule
